### sv/cubic_polynomial_coord_warp_assert.svh
// Assertion macros shared by the coordinate warp modules.
`ifndef CUBIC_POLYNOMIAL_COORD_WARP_ASSERT_SVH
`define CUBIC_POLYNOMIAL_COORD_WARP_ASSERT_SVH

`ifndef SYNTH
`define CPW_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define CPW_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CPW_ASSERT_IMP(label, ante, cons, msg)
`define CPW_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

### sv/cpw_pkg.sv
// Shared types, constants and term tables of the cubic coordinate warp.
package cpw_pkg;

  localparam int COEF_W          = 64;
  localparam int COORD_W         = 32;
  localparam int COEF_FRAC_BITS  = 47;
  localparam int LIMB_W          = 32;
  localparam int MUL_LAT         = 3;
  localparam int SET_COUNT       = 2;
  localparam int TERMS_PER_SET   = 20;
  localparam int TERMS_PER_COORD = TERMS_PER_SET / 2;
  localparam int SLOT_COUNT      = TERMS_PER_SET * SET_COUNT;
  localparam int IDX_W           = 6;
  localparam int LANE_W          = $clog2(TERMS_PER_SET);
  localparam int TERM_MAX_W      = 3 * COORD_W;

  localparam int DEF_COORD_FRAC_BITS = 12;
  localparam int DEF_QUEUE_DEPTH     = 4;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_MAP  = 1'b1;

  localparam logic signed [COORD_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_W-1:0] SAT_MIN = 32'sh8000_0000;

  typedef enum logic {
    KIND_LOAD,
    KIND_MAP
  } kind_t;

  typedef struct packed {
    kind_t                      kind;
    logic [LANE_W-1:0]          lane;
    logic                       coef_set;
    logic [COEF_W-1:0]          value;
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  y;
    logic                       dir;
  } item_t;

  // Number of coordinate fraction steps a term's product is shifted up by.
  function automatic int term_order(input int k);
    int ord;
    if (k == 0) begin
      ord = 3;
    end else if (k <= 2) begin
      ord = 2;
    end else if (k <= 5) begin
      ord = 1;
    end else begin
      ord = 0;
    end
    return ord;
  endfunction

  function automatic int term_width(input int k);
    int w;
    w = (3 - term_order(k)) * COORD_W;
    return w;
  endfunction

endpackage

### sv/cpw_front.sv
// Front end: accepts transactions, drops out-of-range loads and queues the rest.
`include "cubic_polynomial_coord_warp_assert.svh"

module cpw_front #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         action,
  input  logic [5:0]                   coef_index,
  input  logic signed [63:0]           coef_value,
  input  logic signed [31:0]           point_x,
  input  logic signed [31:0]           point_y,
  input  logic                         direction,
  output cpw_pkg::item_t               head,
  output logic                         head_valid,
  input  logic                         pop
);
  import cpw_pkg::*;

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  item_t           entry;
  item_t           mem [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            keep;
  logic            push;

  always_comb begin
    entry.kind     = (action == ACT_MAP) ? KIND_MAP : KIND_LOAD;
    entry.value    = coef_value;
    entry.x        = point_x;
    entry.y        = point_y;
    entry.dir      = direction;
    if (coef_index >= IDX_W'(TERMS_PER_SET)) begin
      entry.coef_set = 1'b1;
      entry.lane     = LANE_W'(coef_index - IDX_W'(TERMS_PER_SET));
    end else begin
      entry.coef_set = 1'b0;
      entry.lane     = LANE_W'(coef_index);
    end
  end

  // Drop loads aimed beyond the last slot: they are accepted but never queued.
  assign keep       = (action == ACT_MAP) || (coef_index < IDX_W'(SLOT_COUNT));
  assign in_ready   = (count != CntW'(QUEUE_DEPTH));
  assign push       = in_valid && in_ready && keep;
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `CPW_ASSERT_IMP(a_pop_not_empty, pop, count != '0, "pop from empty queue")
  `CPW_ASSERT_NXT(a_push_counts, push && !pop, count == $past(count) + 1'b1, "lost push")

endmodule

### sv/cpw_mul.sv
// Three-stage signed multiplier built from 33 by 33 bit limb products.
module cpw_mul #(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic signed [AW-1:0]       a,
  input  logic signed [BW-1:0]       b,
  output logic signed [AW+BW-1:0]    p
);
  import cpw_pkg::*;

  localparam int PW = AW + BW;
  localparam int NA = (AW + LIMB_W - 1) / LIMB_W;
  localparam int NB = (BW + LIMB_W - 1) / LIMB_W;

  logic signed [LIMB_W:0]     a_limb [NA];
  logic signed [LIMB_W:0]     b_limb [NB];
  logic signed [2*LIMB_W+1:0] pp_q   [NA][NB];
  logic signed [PW-1:0]       row_sum [NA];
  logic signed [PW-1:0]       row_q   [NA];
  logic signed [PW-1:0]       prod_sum;

  // Lower limbs are unsigned, the top limb carries the sign.
  for (genvar i = 0; i < NA; i++) begin : g_a
    if (i == NA - 1) begin : g_top
      assign a_limb[i] = (LIMB_W + 1)'(a >>> (LIMB_W * i));
    end else begin : g_low
      assign a_limb[i] = {1'b0, a[LIMB_W*i +: LIMB_W]};
    end
  end

  for (genvar j = 0; j < NB; j++) begin : g_b
    if (j == NB - 1) begin : g_top
      assign b_limb[j] = (LIMB_W + 1)'(b >>> (LIMB_W * j));
    end else begin : g_low
      assign b_limb[j] = {1'b0, b[LIMB_W*j +: LIMB_W]};
    end
  end

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_sum[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_sum[i] = row_sum[i] + (PW'(pp_q[i][j]) << (LIMB_W * j));
      end
    end
    prod_sum = '0;
    for (int i = 0; i < NA; i++) begin
      prod_sum = prod_sum + (row_q[i] << (LIMB_W * i));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_q[i][j] <= a_limb[i] * b_limb[j];
        end
        row_q[i] <= row_sum[i];
      end
      p <= prod_sum;
    end
  end

endmodule

### sv/cpw_back.sv
// Back end: term pipeline, coefficient bank, product sum, rounding and output register.
`include "cubic_polynomial_coord_warp_assert.svh"

module cpw_back #(
  parameter int COORD_FRAC_BITS = 12
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cpw_pkg::item_t       head,
  input  logic                 head_valid,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [31:0]   mapped_x,
  output logic signed [31:0]   mapped_y,
  output logic                 overflow
);
  import cpw_pkg::*;

  localparam int F         = COORD_FRAC_BITS;
  localparam int QUAD_AT   = MUL_LAT;
  localparam int COEF_AT   = 2 * MUL_LAT;
  localparam int PROD_AT   = 3 * MUL_LAT;
  localparam int LAST      = PROD_AT + 3;
  localparam int PAIRS     = TERMS_PER_COORD / 2;
  localparam int W_CONST   = COEF_W + 3 * F;
  localparam int W_LIN     = COEF_W + COORD_W + 2 * F;
  localparam int W_QUAD    = COEF_W + 2 * COORD_W + F;
  localparam int W_CUBE    = COEF_W + 3 * COORD_W;
  localparam int W_A       = (W_CONST > W_LIN) ? W_CONST : W_LIN;
  localparam int W_B       = (W_QUAD > W_CUBE) ? W_QUAD : W_CUBE;
  localparam int AccW      = ((W_A > W_B) ? W_A : W_B) + 4;
  localparam int RND_SHIFT = COEF_FRAC_BITS + 2 * F;
  localparam int HiW       = AccW - RND_SHIFT - COORD_W + 1;
  localparam logic signed [AccW-1:0] HALF = AccW'(1) << (RND_SHIFT - 1);

  logic                        adv;
  logic [LAST:0]               valid_q;
  kind_t                       kind_q     [COEF_AT+1];
  logic signed [COORD_W-1:0]   x_q        [COEF_AT+1];
  logic signed [COORD_W-1:0]   y_q        [COEF_AT+1];
  logic                        dir_q      [COEF_AT+1];
  logic [LANE_W-1:0]           ld_lane_q  [COEF_AT+1];
  logic                        ld_set_q   [COEF_AT+1];
  logic [COEF_W-1:0]           ld_value_q [COEF_AT+1];

  logic signed [2*COORD_W-1:0] xx_m, xy_m, yy_m;
  logic signed [2*COORD_W-1:0] xx_q [QUAD_AT+1:COEF_AT];
  logic signed [2*COORD_W-1:0] xy_q [QUAD_AT+1:COEF_AT];
  logic signed [2*COORD_W-1:0] yy_q [QUAD_AT+1:COEF_AT];
  logic signed [3*COORD_W-1:0] xxx_m, xxy_m, xyy_m, yyy_m;

  logic [COEF_W-1:0]           bank [SET_COUNT][TERMS_PER_SET];
  logic [COEF_W-1:0]           coef [TERMS_PER_SET];
  logic                        ld_hit;
  logic signed [TERM_MAX_W-1:0] term [1:TERMS_PER_COORD-1];
  logic [COEF_W-1:0]           c0_q [SET_COUNT][COEF_AT+1:PROD_AT];

  logic signed [AccW-1:0]      aligned [SET_COUNT][TERMS_PER_COORD];
  logic signed [AccW-1:0]      s1_q    [SET_COUNT][PAIRS];
  logic signed [AccW-1:0]      s2_q    [SET_COUNT][3];
  logic signed [AccW-1:0]      s3_q    [SET_COUNT];
  logic [HiW-1:0]              hi      [SET_COUNT];
  logic                        fits    [SET_COUNT];
  logic signed [COORD_W-1:0]   res     [SET_COUNT];

  // The whole pipeline moves together; the output register parts it from the sink.
  assign adv    = !out_valid || out_ready;
  assign pop    = adv && head_valid;
  assign ld_hit = valid_q[COEF_AT] && (kind_q[COEF_AT] == KIND_LOAD);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= '0;
    end else if (adv) begin
      valid_q[0] <= pop;
      for (int i = 1; i <= LAST; i++) begin
        if (i == COEF_AT + 1) begin
          // Loads end at the coefficient stage.
          valid_q[i] <= valid_q[i-1] && (kind_q[i-1] == KIND_MAP);
        end else begin
          valid_q[i] <= valid_q[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kind_q[0]     <= head.kind;
      x_q[0]        <= head.x;
      y_q[0]        <= head.y;
      dir_q[0]      <= head.dir;
      ld_lane_q[0]  <= head.lane;
      ld_set_q[0]   <= head.coef_set;
      ld_value_q[0] <= head.value;
      for (int i = 1; i <= COEF_AT; i++) begin
        kind_q[i]     <= kind_q[i-1];
        x_q[i]        <= x_q[i-1];
        y_q[i]        <= y_q[i-1];
        dir_q[i]      <= dir_q[i-1];
        ld_lane_q[i]  <= ld_lane_q[i-1];
        ld_set_q[i]   <= ld_set_q[i-1];
        ld_value_q[i] <= ld_value_q[i-1];
      end
      xx_q[QUAD_AT+1] <= xx_m;
      xy_q[QUAD_AT+1] <= xy_m;
      yy_q[QUAD_AT+1] <= yy_m;
      for (int i = QUAD_AT + 2; i <= COEF_AT; i++) begin
        xx_q[i] <= xx_q[i-1];
        xy_q[i] <= xy_q[i-1];
        yy_q[i] <= yy_q[i-1];
      end
      for (int c = 0; c < SET_COUNT; c++) begin
        c0_q[c][COEF_AT+1] <= coef[c*TERMS_PER_COORD];
        for (int i = COEF_AT + 2; i <= PROD_AT; i++) begin
          c0_q[c][i] <= c0_q[c][i-1];
        end
        for (int i = 0; i < PAIRS; i++) begin
          s1_q[c][i] <= aligned[c][2*i] + aligned[c][2*i+1];
        end
        s2_q[c][0] <= s1_q[c][0] + s1_q[c][1];
        s2_q[c][1] <= s1_q[c][2] + s1_q[c][3];
        s2_q[c][2] <= s1_q[c][4];
        s3_q[c]    <= s2_q[c][0] + s2_q[c][1] + s2_q[c][2] + HALF;
      end
    end
  end

  // Squares and cross product.
  cpw_mul #(.AW(COORD_W), .BW(COORD_W)) u_mul_xx (
    .clk, .en(adv), .a(x_q[0]), .b(x_q[0]), .p(xx_m)
  );
  cpw_mul #(.AW(COORD_W), .BW(COORD_W)) u_mul_xy (
    .clk, .en(adv), .a(x_q[0]), .b(y_q[0]), .p(xy_m)
  );
  cpw_mul #(.AW(COORD_W), .BW(COORD_W)) u_mul_yy (
    .clk, .en(adv), .a(y_q[0]), .b(y_q[0]), .p(yy_m)
  );

  // Cubes.
  cpw_mul #(.AW(2*COORD_W), .BW(COORD_W)) u_mul_xxx (
    .clk, .en(adv), .a(xx_m), .b(x_q[QUAD_AT]), .p(xxx_m)
  );
  cpw_mul #(.AW(2*COORD_W), .BW(COORD_W)) u_mul_xxy (
    .clk, .en(adv), .a(xx_m), .b(y_q[QUAD_AT]), .p(xxy_m)
  );
  cpw_mul #(.AW(2*COORD_W), .BW(COORD_W)) u_mul_xyy (
    .clk, .en(adv), .a(yy_m), .b(x_q[QUAD_AT]), .p(xyy_m)
  );
  cpw_mul #(.AW(2*COORD_W), .BW(COORD_W)) u_mul_yyy (
    .clk, .en(adv), .a(yy_m), .b(y_q[QUAD_AT]), .p(yyy_m)
  );

  // Coefficient bank: loads write at the same stage where maps read, so order holds.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < SET_COUNT; s++) begin
        for (int l = 0; l < TERMS_PER_SET; l++) begin
          bank[s][l] <= '0;
        end
      end
    end else if (adv && ld_hit) begin
      bank[ld_set_q[COEF_AT]][ld_lane_q[COEF_AT]] <= ld_value_q[COEF_AT];
    end
  end

  always_comb begin
    for (int l = 0; l < TERMS_PER_SET; l++) begin
      coef[l] = bank[dir_q[COEF_AT]][l];
    end
    term[1] = TERM_MAX_W'(x_q[COEF_AT]);
    term[2] = TERM_MAX_W'(y_q[COEF_AT]);
    term[3] = TERM_MAX_W'(xx_q[COEF_AT]);
    term[4] = TERM_MAX_W'(xy_q[COEF_AT]);
    term[5] = TERM_MAX_W'(yy_q[COEF_AT]);
    term[6] = xxx_m;
    term[7] = xxy_m;
    term[8] = xyy_m;
    term[9] = yyy_m;
  end

  for (genvar c = 0; c < SET_COUNT; c++) begin : g_coord
    for (genvar k = 0; k < TERMS_PER_COORD; k++) begin : g_term
      if (k == 0) begin : g_const
        assign aligned[c][k] = AccW'($signed(c0_q[c][PROD_AT])) << (term_order(k) * F);
      end else begin : g_prod
        localparam int TW = term_width(k);
        logic signed [COEF_W+TW-1:0] prod;
        cpw_mul #(.AW(COEF_W), .BW(TW)) u_mul (
          .clk, .en(adv), .a(coef[c*TERMS_PER_COORD+k]), .b(term[k][TW-1:0]), .p(prod)
        );
        assign aligned[c][k] = AccW'(prod) << (term_order(k) * F);
      end
    end
  end

  // Round has been added already; drop the fraction and saturate.
  always_comb begin
    for (int c = 0; c < SET_COUNT; c++) begin
      hi[c]   = s3_q[c][AccW-1 -: HiW];
      fits[c] = (hi[c] == '0) || (hi[c] == '1);
      if (fits[c]) begin
        res[c] = s3_q[c][RND_SHIFT +: COORD_W];
      end else begin
        res[c] = s3_q[c][AccW-1] ? SAT_MIN : SAT_MAX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= valid_q[LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mapped_x <= res[0];
      mapped_y <= res[1];
      overflow <= !fits[0] || !fits[1];
    end
  end

  `CPW_ASSERT_IMP(a_result_from_pipe, $rose(out_valid), $past(valid_q[LAST]), "stray result")
  `CPW_ASSERT_NXT(a_stall_hold, out_valid && !out_ready, valid_q == $past(valid_q), "moved on stall")

endmodule

### sv/cubic_polynomial_coord_warp.sv
// Path from an accepted transaction to its result (empty queue, ready sink): the queue register,
// three multiplier stages, a 3-level adder tree and the output register.
// Throughput: one transaction per cycle unless stalled, loads and maps alike; fully pipelined.
// Output backpressure freezes the back pipeline; the input queue keeps accepting until full.
// Reset clears the queue, the pipeline valids, the output valid and all 40 coefficients to zero.
module cubic_polynomial_coord_warp #(
  parameter int COORD_FRAC_BITS = cpw_pkg::DEF_COORD_FRAC_BITS,
  parameter int QUEUE_DEPTH     = cpw_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 action,
  input  logic [5:0]           coef_index,
  input  logic signed [63:0]   coef_value,
  input  logic signed [31:0]   point_x,
  input  logic signed [31:0]   point_y,
  input  logic                 direction,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [31:0]   mapped_x,
  output logic signed [31:0]   mapped_y,
  output logic                 overflow
);
  import cpw_pkg::*;

  item_t head;
  logic  head_valid;
  logic  pop;

  cpw_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
    .clk,
    .rst,
    .in_valid,
    .in_ready,
    .action,
    .coef_index,
    .coef_value,
    .point_x,
    .point_y,
    .direction,
    .head,
    .head_valid,
    .pop
  );

  cpw_back #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_back (
    .clk,
    .rst,
    .head,
    .head_valid,
    .pop,
    .out_valid,
    .out_ready,
    .mapped_x,
    .mapped_y,
    .overflow
  );

endmodule
